// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clk_i, off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge.
`define SNO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sno assertion failed");

// Condition must never be true.
`define SNO_ASSERT_NEVER(lbl, cond) \
  `SNO_ASSERT(lbl, !(cond))

`endif

// File: rtl/core/sno_pkg.sv
// ---------------------------------------------------------------------------
// sno_pkg
// Widths, pipeline payload type and clamp helpers for the segment offsetter.
// ---------------------------------------------------------------------------
package sno_pkg;

  localparam int CW  = 16;          // coordinate width
  localparam int OW  = 16;          // offset width
  localparam int DW  = CW + 1;      // endpoint difference / magnitude / root
  localparam int SQW = 2 * DW;      // radicand
  localparam int PW  = CW + OW;     // |d| * |off| product
  localparam int EW  = CW + OW + 1; // unclamped sums

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;
    logic [OW-1:0]        ao;
    logic                 negx;
    logic                 negy;
    logic                 degen;
    logic [SQW-1:0]       rad;     // radicand, consumed two bits per cell
    logic [DW+1:0]        srem;    // root remainder
    logic [DW-1:0]        root;
    logic [DW:0]          xrem;    // divider partial remainders
    logic [DW:0]          yrem;
    logic [OW-1:0]        xlo;     // dividend low bits, then quotient
    logic [OW-1:0]        ylo;
  } pl_t;

  function automatic logic over(input logic signed [EW-1:0] v);
    over = !((&v[EW-1:CW-1]) || !(|v[EW-1:CW-1]));
  endfunction

  function automatic logic signed [CW-1:0] clip(input logic signed [EW-1:0] v);
    if (over(v)) begin
      clip = v[EW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      clip = v[CW-1:0];
    end
  endfunction

endpackage

// File: rtl/core/sno_sqrt_cell.sv
// ---------------------------------------------------------------------------
// sno_sqrt_cell
// One restoring square root step: one root bit per cell.
// ---------------------------------------------------------------------------
module sno_sqrt_cell import sno_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  pl_t  pl_i,
  output logic valid_o,
  output pl_t  pl_o
);

  logic [DW+3:0] trem, trial;
  logic          ge;
  pl_t           nxt;
  logic          valid_q;
  pl_t           pl_q;

  always_comb begin
    trem  = {pl_i.srem, pl_i.rad[SQW-1 -: 2]};
    trial = {2'b00, pl_i.root, 2'b01};
    ge    = (trem >= trial);
    nxt       = pl_i;
    nxt.srem  = ge ? (DW+2)'(trem - trial) : trem[DW+1:0];
    nxt.root  = {pl_i.root[DW-2:0], ge};
    nxt.rad   = {pl_i.rad[SQW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign pl_o    = pl_q;

endmodule

// File: rtl/core/sno_div_cell.sv
// ---------------------------------------------------------------------------
// sno_div_cell
// One restoring divide step for both displacement quotients.
// ---------------------------------------------------------------------------
module sno_div_cell import sno_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  pl_t  pl_i,
  output logic valid_o,
  output pl_t  pl_o
);

  logic [DW:0] len, tx, ty;
  logic        gx, gy;
  pl_t         nxt;
  logic        valid_q;
  pl_t         pl_q;

  always_comb begin
    len = {1'b0, pl_i.root};
    tx  = {pl_i.xrem[DW-1:0], pl_i.xlo[OW-1]};
    ty  = {pl_i.yrem[DW-1:0], pl_i.ylo[OW-1]};
    gx  = (tx >= len);
    gy  = (ty >= len);
    nxt      = pl_i;
    nxt.xrem = gx ? (tx - len) : tx;
    nxt.yrem = gy ? (ty - len) : ty;
    nxt.xlo  = {pl_i.xlo[OW-2:0], gx};
    nxt.ylo  = {pl_i.ylo[OW-2:0], gy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign pl_o    = pl_q;

endmodule

// File: rtl/core/segment_normal_offset.sv
// Pipeline: 3 + (CW+1) + OW + 1 = 37 register stages at 16-bit widths, the
// first loaded at the accept, set by one square root cell per root bit and
// one divider cell per quotient bit.
// Throughput: one item per cycle; the whole chain advances together and
// holds only while a finished item waits on the output register.
// Reset: rst_ni (async, active low) clears all valid bits; no clearing pass.
// ---------------------------------------------------------------------------
// segment_normal_offset
// Shifts a segment along its normal by distance*(dy,-dx)/isqrt(dx^2+dy^2),
// with saturation of the moved endpoints and of the displacement.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_normal_offset import sno_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // start_x, start_y, end_x, end_y, distance (lowest bit up)
  input  logic [5*CW-1:0]   s_axis_tdata,
  // island
  input  logic [0:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // new_start_x, new_start_y, new_end_x, new_end_y, shift_x, shift_y
  output logic [6*CW-1:0]   m_axis_tdata,
  // degenerate, saturated
  output logic [1:0]        m_axis_tuser
);

  // Global advance: the chain moves unless the output item is held.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---- stage A: differences, magnitudes, signs --------------------------
  logic signed [CW-1:0] in_x1, in_y1, in_x2, in_y2;
  logic signed [OW-1:0] in_off;
  logic signed [DW-1:0] dx, dy;
  logic signed [OW:0]   offx, offn;
  pl_t                  a_d, a_q;
  logic                 a_v_q;

  always_comb begin
    in_x1  = s_axis_tdata[0*CW +: CW];
    in_y1  = s_axis_tdata[1*CW +: CW];
    in_x2  = s_axis_tdata[2*CW +: CW];
    in_y2  = s_axis_tdata[3*CW +: CW];
    in_off = s_axis_tdata[4*CW +: OW];
    dx     = DW'(in_x2) - DW'(in_x1);
    dy     = DW'(in_y2) - DW'(in_y1);
    offx   = (OW+1)'(in_off);
    offn   = s_axis_tuser[0] ? -offx : offx;  // exact, one bit wider
    a_d       = '0;
    a_d.x1    = in_x1;
    a_d.y1    = in_y1;
    a_d.x2    = in_x2;
    a_d.y2    = in_y2;
    a_d.ax    = dx[DW-1] ? DW'(-dx) : dx;
    a_d.ay    = dy[DW-1] ? DW'(-dy) : dy;
    a_d.ao    = offn[OW] ? OW'(-offn) : offn[OW-1:0];
    a_d.negx  = dy[DW-1] ^ offn[OW];
    a_d.negy  = (!dx[DW-1] && (dx != '0)) ^ offn[OW];
    a_d.degen = (dx == '0) && (dy == '0);
  end

  // ---- stage B: squares and numerators -----------------------------------
  pl_t            b_q;
  logic           b_v_q;
  logic [SQW-1:0] sqx_q, sqy_q;
  logic [PW-1:0]  px_q, py_q;

  // ---- stage C: radicand sum, cell chain seed ----------------------------
  pl_t  c_d, c_q;
  logic c_v_q;

  always_comb begin
    c_d      = b_q;
    c_d.rad  = sqx_q + sqy_q;
    c_d.srem = '0;
    c_d.root = '0;
    c_d.xrem = (DW+1)'(px_q[PW-1:OW]);
    c_d.yrem = (DW+1)'(py_q[PW-1:OW]);
    c_d.xlo  = px_q[OW-1:0];
    c_d.ylo  = py_q[OW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= s_axis_tvalid;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      b_q   <= a_q;
      sqx_q <= a_q.ax * a_q.ax;
      sqy_q <= a_q.ay * a_q.ay;
      px_q  <= PW'(a_q.ay * a_q.ao);
      py_q  <= PW'(a_q.ax * a_q.ao);
      c_q   <= c_d;
    end
  end

  // ---- square root chain: one root bit per cell --------------------------
  pl_t  sq_pl [DW+1];
  logic sq_v  [DW+1];
  assign sq_pl[0] = c_q;
  assign sq_v[0]  = c_v_q;

  for (genvar i = 0; i < DW; i++) begin : g_sqrt
    sno_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .pl_i    (sq_pl[i]),
      .valid_o (sq_v[i+1]),
      .pl_o    (sq_pl[i+1])
    );
  end

  // ---- divider chain: one quotient bit per cell --------------------------
  pl_t  dv_pl [OW+1];
  logic dv_v  [OW+1];
  assign dv_pl[0] = sq_pl[DW];
  assign dv_v[0]  = sq_v[DW];

  for (genvar i = 0; i < OW; i++) begin : g_div
    sno_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[i]),
      .pl_i    (dv_pl[i]),
      .valid_o (dv_v[i+1]),
      .pl_o    (dv_pl[i+1])
    );
  end

  // ---- output: sign, move, clamp -----------------------------------------
  pl_t                  f;
  logic signed [OW:0]   sxv, syv;
  logic signed [EW-1:0] ex, ey, nsx, nsy, nex, ney;
  logic [6*CW-1:0]      out_data_d, out_data_q;
  logic [1:0]           out_user_d, out_user_q;
  logic                 out_v_q;

  always_comb begin
    f   = dv_pl[OW];
    sxv = f.negx ? -{1'b0, f.xlo} : {1'b0, f.xlo};
    syv = f.negy ? -{1'b0, f.ylo} : {1'b0, f.ylo};
    if (f.degen) begin
      sxv = '0;
      syv = '0;
    end
    ex  = EW'(sxv);
    ey  = EW'(syv);
    nsx = EW'(f.x1) + ex;
    nsy = EW'(f.y1) + ey;
    nex = EW'(f.x2) + ex;
    ney = EW'(f.y2) + ey;
    out_data_d = {clip(ey), clip(ex), clip(ney), clip(nex), clip(nsy), clip(nsx)};
    out_user_d = {over(nsx) | over(nsy) | over(nex) | over(ney) | over(ex) | over(ey),
                  f.degen};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v[OW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---- checks -------------------------------------------------------------
  `SNO_ASSERT(a_degen_noshift, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[4*CW +: 2*CW] == '0))
  `SNO_ASSERT_NEVER(a_degen_nosat, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])
  `SNO_ASSERT(a_accept_enters, (s_axis_tvalid && s_axis_tready) |=> a_v_q)

endmodule

// File: dv/segment_normal_offset_tb.sv
// ---------------------------------------------------------------------------
// segment_normal_offset_tb
// Streams segments through the normal offsetter and checks every result item
// against a typed row expectation or an in-bench model: directed rows first,
// then random segments with varied source/sink idling and a long sink hold-off.
// ---------------------------------------------------------------------------
module segment_normal_offset_tb;
  import sno_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        island;
    logic [15:0] distance;
    logic [15:0] ey;
    logic [15:0] ex;
    logic [15:0] sy;
    logic [15:0] sx;
  } seg_item_t;

  typedef struct packed {
    logic        sat;
    logic        degen;
    logic [15:0] shy;
    logic [15:0] shx;
    logic [15:0] ney;
    logic [15:0] nex;
    logic [15:0] nsy;
    logic [15:0] nsx;
  } seg_res_t;

  typedef struct {
    seg_item_t item;
    bit        typed;  // expectation given in the row
    seg_res_t  res;
  } stim_row_t;

  typedef enum int {PH_SLOW_SINK, PH_SLOW_SRC, PH_NO_IDLE} phase_e;

  localparam int N_RANDOM = 880;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [5*CW-1:0] s_axis_tdata;   // start_x, start_y, end_x, end_y, distance
  logic [0:0]      s_axis_tuser;   // island
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [6*CW-1:0] m_axis_tdata;   // new_start_x/y, new_end_x/y, shift_x/y
  logic [1:0]      m_axis_tuser;   // degenerate, saturated

  segment_normal_offset dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  seg_res_t pending_q[$];
  int       n_mismatch;
  phase_e   phase;
  int       src_idle_pct;
  int       sink_idle_pct;
  logic     sink_hold;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---- model -------------------------------------------------------------
  function automatic logic [15:0] clamp16(input longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1;
      return 16'h7fff;
    end
    if (v < -32768) begin
      sat = 1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic seg_res_t offset_segment(input seg_item_t it);
    longint   x1, y1, x2, y2, off, dx, dy, ax, ay, ao;
    longint   rad, lo, hi, mid, len, sxv, syv;
    bit       sat;
    seg_res_t r;
    x1  = longint'($signed(it.sx));
    y1  = longint'($signed(it.sy));
    x2  = longint'($signed(it.ex));
    y2  = longint'($signed(it.ey));
    off = longint'($signed(it.distance));
    if (it.island) off = -off;   // -(-32768) kept exact
    dx  = x2 - x1;
    dy  = y2 - y1;
    sxv = 0;
    syv = 0;
    sat = 0;
    r.degen = (dx == 0) && (dy == 0);
    if (!r.degen) begin
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      ao  = (off < 0) ? -off : off;
      rad = ax * ax + ay * ay;
      lo  = 0;
      hi  = 64'd1 << 20;
      while (hi - lo > 1) begin
        mid = lo + ((hi - lo) >> 1);
        if (mid * mid <= rad) lo = mid;
        else hi = mid;
      end
      len = lo;
      // magnitudes divided, sign applied after: truncation toward zero
      sxv = (ay * ao) / len;
      syv = (ax * ao) / len;
      if ((dy < 0) != (off < 0)) sxv = -sxv;
      if ((dx > 0) != (off < 0)) syv = -syv;
    end
    r.nsx = clamp16(x1 + sxv, sat);
    r.nsy = clamp16(y1 + syv, sat);
    r.nex = clamp16(x2 + sxv, sat);
    r.ney = clamp16(y2 + syv, sat);
    r.shx = clamp16(sxv, sat);
    r.shy = clamp16(syv, sat);
    r.sat = sat;
    return r;
  endfunction

  // ---- source side -------------------------------------------------------
  task automatic send_item(input seg_item_t it, input seg_res_t exp_res);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.distance, it.ey, it.ex, it.sy, it.sx};
    s_axis_tuser  <= it.island;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_q.push_back(exp_res);
  endtask

  function automatic seg_item_t random_segment();
    seg_item_t it;
    int        kind;
    kind        = $urandom_range(9);
    it.island   = 1'($urandom_range(1));
    it.sx       = 16'($urandom);
    it.sy       = 16'($urandom);
    it.ex       = 16'($urandom);
    it.ey       = 16'($urandom);
    it.distance = 16'($urandom);
    case (kind)
      0: begin  // zero length
        it.ex = it.sx;
        it.ey = it.sy;
      end
      1, 2: begin  // short segment, moderate distance
        it.ex       = it.sx + 16'($signed($urandom_range(0, 40)) - 20);
        it.ey       = it.sy + 16'($signed($urandom_range(0, 40)) - 20);
        it.distance = 16'($signed($urandom_range(0, 2000)) - 1000);
      end
      3: begin  // extreme distance
        it.distance = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      end
      4: begin  // axis aligned
        if ($urandom_range(1)) it.ex = it.sx;
        else it.ey = it.sy;
      end
      default: ;
    endcase
    return it;
  endfunction

  // ---- directed table ----------------------------------------------------
  stim_row_t dir_tab[$];

  function automatic stim_row_t row(input logic [15:0] sx, sy, ex, ey, distance,
                                    input logic isl);
    stim_row_t r;
    r.item  = '{isl, distance, ey, ex, sy, sx};
    r.typed = 0;
    r.res   = '0;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    // zero length: passes through, flagged
    r = row(16'd5, 16'd7, 16'd5, 16'd7, 16'd100, 1'b0);
    r.typed = 1;
    r.res   = '{1'b0, 1'b1, 16'd0, 16'd0, 16'd7, 16'd5, 16'd7, 16'd5};
    dir_tab.push_back(r);
    // horizontal, +3: moves down by 3
    r = row(16'd0, 16'd0, 16'd10, 16'd0, 16'd3, 1'b0);
    r.typed = 1;
    r.res   = '{1'b0, 1'b0, -16'sd3, 16'd0, -16'sd3, 16'd10, -16'sd3, 16'd0};
    dir_tab.push_back(r);
    // same with island: moves up
    r = row(16'd0, 16'd0, 16'd10, 16'd0, 16'd3, 1'b1);
    r.typed = 1;
    r.res   = '{1'b0, 1'b0, 16'd3, 16'd0, 16'd3, 16'd10, 16'd3, 16'd0};
    dir_tab.push_back(r);
    // corners, opposite extremes, extreme distances with both island values
    dir_tab.push_back(row(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0));
    dir_tab.push_back(row(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0));
    dir_tab.push_back(row(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b1));
    dir_tab.push_back(row(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 1'b0));
    dir_tab.push_back(row(16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    dir_tab.push_back(row(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    dir_tab.push_back(row(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 1'b1));
    // shift at or past the range limit: tiny segment, huge distance
    dir_tab.push_back(row(16'd0, 16'd0, 16'd1, 16'd1, 16'h7fff, 1'b0));
    dir_tab.push_back(row(16'd0, 16'd0, 16'hffff, 16'd1, 16'h8000, 1'b1));
    // diagonal with remainders, negative truncation
    dir_tab.push_back(row(16'd3, 16'd4, 16'd6, 16'd8, -16'sd7, 1'b0));
    dir_tab.push_back(row(16'd6, 16'd8, 16'd3, 16'd4, 16'd7, 1'b0));
    dir_tab.push_back(row(16'd0, 16'd0, 16'd1, 16'd2, 16'd0, 1'b1));
    // zero length at extremes
    dir_tab.push_back(row(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1));
    dir_tab.push_back(row(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1));
  end

  // ---- sink side: random stalls, one long counted hold-off ------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    sink_hold = 1'b0;
    wait (phase == PH_NO_IDLE);
    repeat (20) @(posedge clk_i);
    sink_hold <= 1'b1;
    repeat (300) @(posedge clk_i);   // pipeline fills, input stalls
    sink_hold <= 1'b0;
  end

  // ---- result check ------------------------------------------------------
  always @(posedge clk_i) begin
    seg_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[1], m_axis_tuser[0], m_axis_tdata};
      if (pending_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result item %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp nsx=%0d nsy=%0d nex=%0d ney=%0d shx=%0d shy=%0d dg=%b st=%b",
                     $signed(want.nsx), $signed(want.nsy), $signed(want.nex),
                     $signed(want.ney), $signed(want.shx), $signed(want.shy),
                     want.degen, want.sat);
          if (n_mismatch <= 10)
            $display("          got nsx=%0d nsy=%0d nex=%0d ney=%0d shx=%0d shy=%0d dg=%b st=%b",
                     $signed(got.nsx), $signed(got.nsy), $signed(got.nex),
                     $signed(got.ney), $signed(got.shx), $signed(got.shy),
                     got.degen, got.sat);
        end
      end
    end
  end

  // ---- main sequence -----------------------------------------------------
  initial begin
    seg_item_t it;
    int        wait_cyc;
    n_mismatch    = 0;
    phase         = PH_SLOW_SINK;
    src_idle_pct  = 25;
    sink_idle_pct = 51;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_item(dir_tab[i].item,
                dir_tab[i].typed ? dir_tab[i].res : offset_segment(dir_tab[i].item));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        phase         = PH_SLOW_SRC;
        src_idle_pct  = 51;
        sink_idle_pct = 25;
      end else if (n == 2 * N_RANDOM / 3) begin
        phase         = PH_NO_IDLE;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      it = random_segment();
      send_item(it, offset_segment(it));
    end
    s_axis_tvalid <= 1'b0;

    wait_cyc = 0;
    while (pending_q.size() != 0 && wait_cyc < 20000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (60) @(posedge clk_i);   // margin past the pipeline latency

    if (n_mismatch == 0 && pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
